/* sv/sem_pkg.sv */
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants for the RGB Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

	localparam int PIX_W   = 24;
	localparam int GRAD_W  = 11;
	localparam int SUM_W   = 21;
	localparam int ROOT_STEPS = 8;

	localparam logic [SUM_W-1:0] SQ_LIMIT = 21'd65025;
	localparam logic [7:0]       EDGE_MAX = 8'd255;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;

	localparam logic [10:0] WIDTH_RESET  = 11'd640;
	localparam logic [11:0] HEIGHT_RESET = 12'd480;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_GRAD,
		ST_SQUARE,
		ST_ROOT,
		ST_FINISH
	} sem_state_t;

	typedef struct packed {
		logic       accept;
		logic       update;
		logic       grad;
		logic       square;
		logic       root;
		logic [2:0] step;
		logic       finish;
	} sem_cmd_t;

	typedef struct packed {
		logic emit;
		logic out_free;
	} sem_sts_t;

	// channel k of a packed pixel (red in the top byte), as a signed gradient term
	function automatic logic signed [GRAD_W-1:0] chan(input logic [PIX_W-1:0] p,
			input logic [1:0] k);
		logic [7:0] v;
		unique case (k)
			2'd0: v = p[23:16];
			2'd1: v = p[15:8];
			default: v = p[7:0];
		endcase
		return $signed({3'b000, v});
	endfunction

endpackage

/* sv/sem_ctrl.sv */
// ----------------------------------------------------------------------------
// sem_ctrl
// Sequencer: accept, window update, gradient, square, root steps, result.
// ----------------------------------------------------------------------------
module sem_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sem_pkg::sem_sts_t sts,
	output sem_pkg::sem_cmd_t cmd
);

	sem_pkg::sem_state_t state_q, state_d;
	logic [2:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sem_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sem_pkg::ST_ROOT)
				step_q <= step_q + 3'd1;
			else
				step_q <= '0;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.step   = step_q;
		in_ready   = 1'b0;
		unique case (state_q)
			sem_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid)
					state_d = sem_pkg::ST_UPDATE;
			end
			sem_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d = sts.emit ? sem_pkg::ST_GRAD : sem_pkg::ST_IDLE;
			end
			sem_pkg::ST_GRAD: begin
				cmd.grad = 1'b1;
				state_d  = sem_pkg::ST_SQUARE;
			end
			sem_pkg::ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = sem_pkg::ST_ROOT;
			end
			sem_pkg::ST_ROOT: begin
				cmd.root = 1'b1;
				if (step_q == 3'(sem_pkg::ROOT_STEPS - 1))
					state_d = sem_pkg::ST_FINISH;
			end
			sem_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = sem_pkg::ST_IDLE;
				end
			end
			default: state_d = sem_pkg::ST_IDLE;
		endcase
	end

	a_square_to_root: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sem_pkg::ST_SQUARE |=> state_q == sem_pkg::ST_ROOT && step_q == 3'd0)
		else $error("root sequence did not start at step zero");

	a_root_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sem_pkg::ST_ROOT && step_q == 3'd7 |=> state_q == sem_pkg::ST_FINISH)
		else $error("root sequence did not end after eight steps");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.update, cmd.grad, cmd.square, cmd.root, cmd.finish}))
		else $error("more than one datapath command at once");

endmodule

/* sv/sem_datapath.sv */
// ----------------------------------------------------------------------------
// sem_datapath
// Line stores, 3x3 window, position counters, gradients and rounded root.
// ----------------------------------------------------------------------------
module sem_datapath #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4095
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sem_pkg::sem_cmd_t cmd,
	output sem_pkg::sem_sts_t sts,
	input  logic              in_command,
	input  logic [23:0]       in_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [11:0]       cfg_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [23:0]       out_data,
	output logic              out_last
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT + 1) : 1;

	logic [10:0] cfg_w_q;
	logic [11:0] cfg_h_q;
	logic [WW-1:0] w_use;
	logic [HW-1:0] h_use;

	logic [CW-1:0] in_col_q;
	logic [1:0]    in_row_q;   // saturates at two
	logic [CW-1:0] out_col_q;
	logic [HW-1:0] out_row_q;

	logic [23:0] mem_a [MAX_WIDTH];
	logic [23:0] mem_b [MAX_WIDTH];
	logic [23:0] pix_q, a_q, b_q;
	logic [2:0][2:0][23:0] win_q;

	logic signed [10:0] gx_q [3];
	logic signed [10:0] gy_q [3];
	logic [20:0] s_q [3];
	logic [7:0]  r_q [3];
	logic        last_q;
	logic        out_valid_q;
	logic [23:0] out_data_q;

	logic cfg_wr, restart, col_wrap, emit, top_off, bot_off, left_off, right_off, last;
	logic [WW-1:0] in_col_nx, out_col_nx;
	logic [2:0][2:0][23:0] m;
	logic signed [10:0] gx_c [3];
	logic signed [10:0] gy_c [3];
	logic [20:0] s_c [3];
	logic [7:0]  r_c [3];
	logic [7:0]  edge_c [3];

	assign cfg_ready = 1'b1;
	assign cfg_wr  = cfg_valid && (cfg_index == sem_pkg::REG_WIDTH ||
		cfg_index == sem_pkg::REG_HEIGHT);

	always_comb begin
		if (cfg_w_q == '0)
			w_use = WW'(1);
		else if (32'(cfg_w_q) > MAX_WIDTH)
			w_use = WW'(MAX_WIDTH);
		else
			w_use = WW'(cfg_w_q);
		if (cfg_h_q == '0)
			h_use = HW'(1);
		else if (32'(cfg_h_q) > MAX_HEIGHT)
			h_use = HW'(MAX_HEIGHT);
		else
			h_use = HW'(cfg_h_q);
	end

	assign in_col_nx  = WW'(in_col_q) + WW'(1);
	assign out_col_nx = WW'(out_col_q) + WW'(1);
	assign col_wrap   = in_col_nx >= w_use;
	assign emit       = (in_row_q == 2'd2) || (in_row_q == 2'd1 && in_col_q != '0);
	assign top_off    = out_row_q == '0;
	assign bot_off    = out_row_q + HW'(1) >= h_use;
	assign left_off   = out_col_q == '0;
	assign right_off  = out_col_nx >= w_use;
	assign last       = bot_off && right_off;
	assign restart    = cfg_wr || (cmd.finish && last_q);

	assign sts.emit     = emit;
	assign sts.out_free = !out_valid_q || out_ready;

	// line stores: read at accept, written back during update
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			a_q   <= mem_a[in_col_q];
			b_q   <= mem_b[in_col_q];
			pix_q <= in_command ? 24'd0 : in_data;
		end
		if (cmd.update) begin
			mem_a[in_col_q] <= pix_q;
			mem_b[in_col_q] <= a_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q   <= sem_pkg::WIDTH_RESET;
			cfg_h_q   <= sem_pkg::HEIGHT_RESET;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			win_q     <= '0;
		end else begin
			if (cfg_valid && cfg_index == sem_pkg::REG_WIDTH)
				cfg_w_q <= cfg_data[10:0];
			if (cfg_valid && cfg_index == sem_pkg::REG_HEIGHT)
				cfg_h_q <= cfg_data;
			if (restart) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				win_q     <= '0;
			end else begin
				if (cmd.update) begin
					for (int r = 0; r < 3; r++) begin
						win_q[r][0] <= win_q[r][1];
						win_q[r][1] <= win_q[r][2];
					end
					win_q[0][2] <= b_q;
					win_q[1][2] <= a_q;
					win_q[2][2] <= pix_q;
					if (col_wrap) begin
						in_col_q <= '0;
						if (in_row_q != 2'd2)
							in_row_q <= in_row_q + 2'd1;
					end else begin
						in_col_q <= CW'(in_col_nx);
					end
				end
				if (cmd.finish) begin
					if (right_off) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + HW'(1);
					end else begin
						out_col_q <= CW'(out_col_nx);
					end
				end
			end
		end
	end

	// masked window and Sobel gradients
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if ((r == 0 && top_off) || (r == 2 && bot_off) ||
						(c == 0 && left_off) || (c == 2 && right_off))
					m[r][c] = '0;
				else
					m[r][c] = win_q[r][c];
			end
		end
		for (int k = 0; k < 3; k++) begin
			gx_c[k] = (sem_pkg::chan(m[0][2], 2'(k)) + 11'sd2 * sem_pkg::chan(m[1][2], 2'(k))
				+ sem_pkg::chan(m[2][2], 2'(k)))
				- (sem_pkg::chan(m[0][0], 2'(k)) + 11'sd2 * sem_pkg::chan(m[1][0], 2'(k))
				+ sem_pkg::chan(m[2][0], 2'(k)));
			gy_c[k] = (sem_pkg::chan(m[2][0], 2'(k)) + 11'sd2 * sem_pkg::chan(m[2][1], 2'(k))
				+ sem_pkg::chan(m[2][2], 2'(k)))
				- (sem_pkg::chan(m[0][0], 2'(k)) + 11'sd2 * sem_pkg::chan(m[0][1], 2'(k))
				+ sem_pkg::chan(m[0][2], 2'(k)));
		end
	end

	always_comb begin
		logic signed [21:0] px, py;
		logic [7:0]  t;
		logic [15:0] tt;
		logic [16:0] rr;
		for (int k = 0; k < 3; k++) begin
			px = gx_q[k] * gx_q[k];
			py = gy_q[k] * gy_q[k];
			s_c[k] = 21'(px) + 21'(py);
			t  = r_q[k] | (8'h80 >> cmd.step);
			tt = t * t;
			r_c[k] = ({5'b0, tt} <= s_q[k]) ? t : r_q[k];
			rr = 17'(r_q[k]) * 17'(r_q[k]) + 17'(r_q[k]);
			if (s_q[k] > sem_pkg::SQ_LIMIT)
				edge_c[k] = sem_pkg::EDGE_MAX;
			else if (s_q[k] > {4'b0, rr})
				edge_c[k] = r_q[k] + 8'd1;
			else
				edge_c[k] = r_q[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (cmd.grad) begin
				gx_q[k] <= gx_c[k];
				gy_q[k] <= gy_c[k];
			end
			if (cmd.square) begin
				s_q[k] <= s_c[k];
				r_q[k] <= '0;
			end
			if (cmd.root)
				r_q[k] <= r_c[k];
		end
		if (cmd.grad)
			last_q <= last;
		if (cmd.finish)
			out_data_q <= {edge_c[2], edge_c[1], edge_c[0]};
	end

	logic out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.finish)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish)
			out_last_q <= last_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	a_finish_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result loaded over a beat still waiting");

	a_in_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(in_col_q) < w_use)
		else $error("input column beyond frame width");

	a_out_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(out_col_q) < w_use)
		else $error("output column beyond frame width");

endmodule

/* sv/sobel_edge_magnitude_rgb.sv */
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// 3x3 Sobel edge magnitude on RGB pixels in raster order, rounded, sat to 255.
// ----------------------------------------------------------------------------
// Input beats: tdata holds red, green, blue (red lowest); tuser is the command,
// 0 for a pixel, 1 for a drain step carrying no pixel. Output beats carry the
// red, green and blue edge magnitudes in tdata and flag the frame's last
// result on tlast. A result belongs to the input that went in frame_width+1
// beats earlier; frame_width+1 drain beats after the last pixel flush the
// frame. Register 0 is frame_width, register 1 frame_height; a write restarts
// the frame. cfg_ready is always high; the user must let writes go in only
// while no beat is in flight; the block does not enforce it. A beat takes a
// line-store read and a window update, and no new beat is taken until it is
// done; one that yields a result also takes gradient, squaring, an eight-step
// square root run for the three channels in parallel and the rounding step.
// The output register holds a result while the receiver stalls; the block
// keeps accepting beats until the next result is ready to be loaded.
// Reset restores 640x480 and clears the counters and window; line stores
// are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4095
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
	input  logic        s_axis_tuser,   // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // red_edge, green_edge, blue_edge
	output logic        m_axis_tlast,   // frame_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	sem_pkg::sem_cmd_t cmd;
	sem_pkg::sem_sts_t sts;

	sem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sem_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_command (s_axis_tuser),
		.in_data    ({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_last   (m_axis_tlast)
	);

endmodule
